// File: rtl/crb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crb_pkg: shared types and constants of the glyph class range builder
// item and result layouts, status codes and the class bit helper
// ----------------------------------------------------------------------------
package crb_pkg;

	localparam int unsigned GLYPH_W     = 16;
	localparam int unsigned CLASS_IN_W  = 16;
	localparam int unsigned CLASS_W     = 3;
	localparam int unsigned MASK_W      = 5;
	localparam int unsigned STATUS_W    = 2;
	localparam int unsigned NUM_CLASSES = 5;
	localparam logic [GLYPH_W-1:0] MAX_ID = 16'hFFFF;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned PTR_W      = 2;
	localparam int unsigned CNT_W      = 3;

	localparam int unsigned S_DATA_W = 32;
	localparam int unsigned M_DATA_W = 40;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_CLASS    = 2'd1,
		ST_ORDER    = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef struct packed {
		logic [GLYPH_W-1:0]    glyph_id;
		logic [CLASS_IN_W-1:0] glyph_class;
		logic                  end_of_list;
	} item_t;

	typedef struct packed {
		logic [GLYPH_W-1:0] range_start;
		logic [GLYPH_W-1:0] range_end;
		logic [CLASS_W-1:0] range_class;
		logic               final_result;
		status_t            status;
		logic [MASK_W-1:0]  classes_present;
	} result_t;

	typedef struct packed {
		logic    push0;
		logic    push1;
		result_t res0;
		result_t res1;
	} push_t;

	function automatic logic [MASK_W-1:0] class_bit(input logic [CLASS_W-1:0] cls);
		logic [MASK_W-1:0] b;
		b = '0;
		for (int i = 0; i < MASK_W; i++) begin
			if (cls == CLASS_W'(i)) begin
				b[i] = 1'b1;
			end
		end
		return b;
	endfunction

endpackage

// File: rtl/crb_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crb_core: run tracking and range emission
// holds the open run and the class mask, turns one pair into one error result or up to two ranges
// ----------------------------------------------------------------------------
module crb_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  crb_pkg::item_t item,
	output crb_pkg::push_t push
);
	import crb_pkg::*;

	logic [GLYPH_W-1:0] rf_q, en_q;
	logic [CLASS_W-1:0] rc_q;
	logic [MASK_W-1:0]  seen_q;
	logic               await_q, skip_q;

	logic [GLYPH_W-1:0] nx_rf, nx_en, rf0, en0;
	logic [CLASS_W-1:0] nx_rc, rc0;
	logic [MASK_W-1:0]  nx_seen, mask0, m1;
	logic               nx_await, nx_skip, do_fail, class_big, last;
	status_t            fail_st;
	push_t              pu;
	logic [GLYPH_W-1:0] g;
	logic [CLASS_IN_W-1:0] c;

	assign g         = item.glyph_id;
	assign c         = item.glyph_class;
	assign last      = item.end_of_list;
	assign class_big = c >= CLASS_IN_W'(NUM_CLASSES);

	always_comb begin
		nx_rf    = rf_q;
		nx_en    = en_q;
		nx_rc    = rc_q;
		nx_seen  = seen_q;
		nx_await = await_q;
		nx_skip  = skip_q;
		pu       = '0;
		do_fail  = 1'b0;
		fail_st  = ST_OK;
		rf0      = rf_q;
		en0      = en_q;
		rc0      = rc_q;
		mask0    = seen_q;
		m1       = '0;
		if (skip_q) begin
			if (last) begin
				nx_skip  = 1'b0;
				nx_await = 1'b1;
			end
		end else begin
			// first pair of a table opens a run of its own
			if (await_q) begin
				mask0 = '0;
				rf0   = g;
				en0   = g;
				rc0   = c[CLASS_W-1:0];
			end
			if (await_q && class_big) begin
				do_fail = 1'b1;
				fail_st = ST_CLASS;
			end else if (g == en0 && c == CLASS_IN_W'(rc0)) begin
				if (last) begin
					pu.push0 = 1'b1;
					pu.res0  = '{range_start: rf0, range_end: g, range_class: rc0,
						final_result: 1'b1, status: ST_OK,
						classes_present: mask0 | class_bit(rc0)};
					nx_seen  = mask0 | class_bit(rc0);
					nx_await = 1'b1;
				end else if (en0 == MAX_ID) begin
					do_fail = 1'b1;
					fail_st = ST_OVERFLOW;
				end else begin
					nx_rf    = rf0;
					nx_en    = en0 + GLYPH_W'(1);
					nx_rc    = rc0;
					nx_seen  = mask0;
					nx_await = 1'b0;
				end
			end else if (en0 > g) begin
				do_fail = 1'b1;
				fail_st = ST_ORDER;
			end else if (class_big) begin
				do_fail = 1'b1;
				fail_st = ST_CLASS;
			end else if (!last && g == MAX_ID) begin
				do_fail = 1'b1;
				fail_st = ST_OVERFLOW;
			end else begin
				// close the open run
				m1       = mask0 | class_bit(rc0);
				pu.push0 = 1'b1;
				pu.res0  = '{range_start: rf0, range_end: en0 - GLYPH_W'(1),
					range_class: rc0, final_result: 1'b0, status: ST_OK,
					classes_present: '0};
				if (last) begin
					pu.push1 = 1'b1;
					pu.res1  = '{range_start: g, range_end: g,
						range_class: c[CLASS_W-1:0], final_result: 1'b1, status: ST_OK,
						classes_present: m1 | class_bit(c[CLASS_W-1:0])};
					nx_seen  = m1 | class_bit(c[CLASS_W-1:0]);
					nx_await = 1'b1;
				end else begin
					nx_rf    = g;
					nx_rc    = c[CLASS_W-1:0];
					nx_en    = g + GLYPH_W'(1);
					nx_seen  = m1;
					nx_await = 1'b0;
				end
			end
			if (do_fail) begin
				pu.push0 = 1'b1;
				pu.push1 = 1'b0;
				pu.res0  = '{range_start: '0, range_end: '0, range_class: '0,
					final_result: 1'b1, status: fail_st, classes_present: mask0};
				nx_seen  = mask0;
				if (last) begin
					nx_await = 1'b1;
				end else begin
					nx_skip = 1'b1;
				end
			end
		end
	end

	always_comb begin
		push       = pu;
		push.push0 = pu.push0 & adv;
		push.push1 = pu.push1 & adv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_q    <= '0;
			en_q    <= '0;
			rc_q    <= '0;
			seen_q  <= '0;
			await_q <= 1'b1;
			skip_q  <= 1'b0;
		end else if (adv) begin
			rf_q    <= nx_rf;
			en_q    <= nx_en;
			rc_q    <= nx_rc;
			seen_q  <= nx_seen;
			await_q <= nx_await;
			skip_q  <= nx_skip;
		end
	end

endmodule

// File: rtl/crb_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crb_out_fifo: result queue
// takes up to two results a cycle, while popped hands out one a cycle
// ----------------------------------------------------------------------------
module crb_out_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  crb_pkg::push_t   push,
	input  logic             pop,
	output logic             room,
	output logic             head_valid,
	output crb_pkg::result_t head
);
	import crb_pkg::*;

	result_t          mem [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q, wr1;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] n_push;
	logic             do_pop;

	assign wr1        = wr_q + PTR_W'(1);
	assign n_push     = CNT_W'(push.push0) + CNT_W'(push.push1);
	assign head_valid = count_q != '0;
	assign do_pop     = pop & head_valid;
	// keep space for a two-range transaction
	assign room       = count_q <= CNT_W'(FIFO_DEPTH - 2);
	assign head       = mem[rd_q];

	always_ff @(posedge clk) begin
		for (int i = 0; i < FIFO_DEPTH; i++) begin
			if (push.push0 && wr_q == PTR_W'(i)) begin
				mem[i] <= push.res0;
			end else if (push.push1 && wr1 == PTR_W'(i)) begin
				mem[i] <= push.res1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + n_push[PTR_W-1:0];
			rd_q    <= rd_q + PTR_W'(do_pop);
			count_q <= count_q + n_push - CNT_W'(do_pop);
		end
	end

endmodule

// File: rtl/glyph_class_range_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_class_range_builder: merges ascending (glyph, class) pairs into ranges
//
// channel  dir  tdata (low bit up)                          tuser   tlast
// s_*      in   glyph_id[15:0], glyph_class[31:16]          -       end_of_list
// m_*      out  range_start[15:0], range_end[31:16],        status  final_result
//               range_class[34:32], classes_present[39:35]
//
// one pair per cycle while the queue has room; a pair is registered, then handled
// by the core and its ranges enter a four-entry result queue
// a pair that closes a table with two ranges yields two results on the output
// a held pair stalls the input while the queue holds more than two results
// reset clears the queue and the run state, next pair opens a new table
// ----------------------------------------------------------------------------
module glyph_class_range_builder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // glyph_id, glyph_class
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // range_start, range_end, range_class, classes_present
	output logic [1:0]  m_tuser,  // status
	output logic        m_tlast
);
	import crb_pkg::*;

	logic    valid_s1, adv, room;
	item_t   item_s1;
	push_t   push;
	result_t head;

	assign adv      = valid_s1 & room;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= '{glyph_id: s_tdata[GLYPH_W-1:0],
				glyph_class: s_tdata[S_DATA_W-1:GLYPH_W], end_of_list: s_tlast};
		end
	end

	crb_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.push   (push)
	);

	crb_out_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (m_tready),
		.room       (room),
		.head_valid (m_tvalid),
		.head       (head)
	);

	assign m_tdata = {head.classes_present, head.range_class, head.range_end,
		head.range_start};
	assign m_tuser = head.status;
	assign m_tlast = head.final_result;

endmodule
